[src/rsob_pkg.sv]
// ----------------------------------------------------------------------------
// rsob_pkg: shared types and constants for the RGBA source-over blender
// Channel widths, the divide-by-255 reciprocal and the item structs that
// travel between the blender's pipeline sections.
// ----------------------------------------------------------------------------
package rsob_pkg;

  // Channel geometry
  localparam int CH_W      = 8;
  localparam int NUM_LANES = 3;

  // Full-scale level and rounding bias of the alpha term
  localparam logic [CH_W-1:0] FULL_LEVEL = 8'd255;
  localparam logic [15:0]     HALF_DOWN  = 16'd127;

  // floor(x / 255) == (x * 0x8081) >> 23, exact for any 16-bit x
  localparam logic [31:0] RECIP_255   = 32'h0000_8081;
  localparam int          RECIP_SHIFT = 23;

  // Color numerator: two 16-bit products plus rounding, below 2^17
  localparam int NUM_W = 17;

  // Divider: restoring steps per pipeline stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = CH_W / DIV_STEPS;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [NUM_W-1:0] num_t;

  // Lane order in the color arrays: 0 red, 1 green, 2 blue
  typedef struct packed {
    chan_t [NUM_LANES-1:0] src_col;
    chan_t                 src_alpha;
    chan_t [NUM_LANES-1:0] dst_col;
    chan_t                 dst_alpha;
  } pix_t;

  // Item between the product section and the divider
  typedef struct packed {
    num_t [NUM_LANES-1:0] num;
    chan_t                alpha;
  } mix_t;

  typedef struct packed {
    chan_t [NUM_LANES-1:0] col;
    chan_t                 alpha;
  } res_t;

  // Quotient by 255; callers keep x at or below 65279 so the result fits
  function automatic chan_t div255(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * RECIP_255;
    return prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
  endfunction

endpackage

[src/rsob_if.sv]
// ----------------------------------------------------------------------------
// rsob_if: valid/ready channels of the RGBA source-over blender
// Pixel-pair input channel and blended-pixel result channel.
// ----------------------------------------------------------------------------
interface rsob_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface rsob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha_level;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha_level,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha_level,
    output ready
  );
endinterface

[src/rsob_front.sv]
// ----------------------------------------------------------------------------
// rsob_front: product section of the source-over blender
// Five register stages that form the output alpha and, per color lane,
// the numerator sc*sa + floor(dc*da*(255-sa)/255) + oa/2.
// ----------------------------------------------------------------------------
module rsob_front import rsob_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pix_t in_pix,
  output logic out_valid,
  input  logic out_ready,
  output mix_t out_mix
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] en;

  // Stage A: da*(255-sa) and the premultiplied source
  logic [15:0]                 a_t_r, a_t_nxt;
  logic [NUM_LANES-1:0][15:0]  a_sp_r, a_sp_nxt;
  chan_t [NUM_LANES-1:0]       a_dc_r;
  chan_t                       a_sa_r;
  chan_t                       a_isa;

  // Stage B: t / 255 and output alpha
  chan_t                       b_quo_r, b_quo_nxt;
  chan_t                       b_oa_r, b_oa_nxt;
  logic [15:0]                 b_t_r;
  logic [NUM_LANES-1:0][15:0]  b_sp_r;
  chan_t [NUM_LANES-1:0]       b_dc_r;

  // Stage C: dc * (t / 255) and dc * (t % 255)
  chan_t                       c_rem;
  logic [NUM_LANES-1:0][15:0]  c_hi_r, c_hi_nxt;
  logic [NUM_LANES-1:0][15:0]  c_lo_r, c_lo_nxt;
  logic [NUM_LANES-1:0][15:0]  c_sp_r;
  chan_t                       c_oa_r;

  // Stage D: remainder product over 255
  chan_t [NUM_LANES-1:0]       d_lo_r, d_lo_nxt;
  logic [NUM_LANES-1:0][15:0]  d_hi_r;
  logic [NUM_LANES-1:0][15:0]  d_sp_r;
  chan_t                       d_oa_r;

  // Stage E: numerator sum
  mix_t                        e_mix_r, e_mix_nxt;

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];
  assign out_mix   = e_mix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // Stage A products
  always_comb begin
    a_isa   = FULL_LEVEL - in_pix.src_alpha;
    a_t_nxt = 16'(in_pix.dst_alpha) * 16'(a_isa);
    for (int c = 0; c < NUM_LANES; c++) begin
      a_sp_nxt[c] = 16'(in_pix.src_col[c]) * 16'(in_pix.src_alpha);
    end
  end

  // Stage B: t + 127 stays below 65279, so both quotients fit 8 bits
  always_comb begin
    b_quo_nxt = div255(a_t_r);
    b_oa_nxt  = a_sa_r + div255(a_t_r + HALF_DOWN);
  end

  // Stage C: t % 255 = t - 256*q + q
  always_comb begin
    c_rem = CH_W'(b_t_r - {b_quo_r, 8'h00} + 16'(b_quo_r));
    for (int c = 0; c < NUM_LANES; c++) begin
      c_hi_nxt[c] = 16'(b_dc_r[c]) * 16'(b_quo_r);
      c_lo_nxt[c] = 16'(b_dc_r[c]) * 16'(c_rem);
    end
  end

  // Stage D
  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      d_lo_nxt[c] = div255(c_lo_r[c]);
    end
  end

  // Stage E: add source part, destination part and half the alpha
  always_comb begin
    e_mix_nxt.alpha = d_oa_r;
    for (int c = 0; c < NUM_LANES; c++) begin
      e_mix_nxt.num[c] = NUM_W'(d_sp_r[c]) + NUM_W'(d_hi_r[c]) + NUM_W'(d_lo_r[c])
                       + NUM_W'(d_oa_r >> 1);
    end
  end

  // Payload registers, loaded with their stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_t_r  <= a_t_nxt;
      a_sp_r <= a_sp_nxt;
      a_dc_r <= in_pix.dst_col;
      a_sa_r <= in_pix.src_alpha;
    end
    if (en[1]) begin
      b_quo_r <= b_quo_nxt;
      b_oa_r  <= b_oa_nxt;
      b_t_r   <= a_t_r;
      b_sp_r  <= a_sp_r;
      b_dc_r  <= a_dc_r;
    end
    if (en[2]) begin
      c_hi_r <= c_hi_nxt;
      c_lo_r <= c_lo_nxt;
      c_sp_r <= b_sp_r;
      c_oa_r <= b_oa_r;
    end
    if (en[3]) begin
      d_lo_r <= d_lo_nxt;
      d_hi_r <= c_hi_r;
      d_sp_r <= c_sp_r;
      d_oa_r <= c_oa_r;
    end
    if (en[4]) begin
      e_mix_r <= e_mix_nxt;
    end
  end

endmodule

[src/rsob_div.sv]
// ----------------------------------------------------------------------------
// rsob_div: pipelined rounding divider of the source-over blender
// Divides each lane numerator by the output alpha with a restoring
// divider, two quotient bits per stage; saturates at full level and
// forces zero color when the alpha is zero.
// ----------------------------------------------------------------------------
module rsob_div import rsob_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  mix_t in_mix,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int LAST = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] en;

  // Partial remainders and overflow flags are dropped at the last stage
  num_t  [NUM_LANES-1:0] rem_r   [LAST];
  num_t  [NUM_LANES-1:0] rem_nxt [LAST];
  logic  [NUM_LANES-1:0] ovf_r   [LAST];
  logic  [NUM_LANES-1:0] ovf_nxt [LAST];
  chan_t [NUM_LANES-1:0] q_r     [DIV_STAGES];
  chan_t [NUM_LANES-1:0] q_nxt   [DIV_STAGES];
  chan_t                 oa_r    [DIV_STAGES];
  chan_t                 oa_nxt  [DIV_STAGES];

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    en[LAST] = !v_r[LAST] || out_ready;
    for (int s = LAST - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[LAST];

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      out_res.col[c] = q_r[LAST][c];
    end
    out_res.alpha = oa_r[LAST];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // Restoring steps; the first stage also flags quotients of 256 or more
  always_comb begin
    num_t  rem;
    num_t  sh;
    chan_t q;
    chan_t oa;
    logic  ovf;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        oa = in_mix.alpha;
      end else begin
        oa = oa_r[s-1];
      end
      oa_nxt[s] = oa;
      for (int c = 0; c < NUM_LANES; c++) begin
        if (s == 0) begin
          rem = in_mix.num[c];
          q   = '0;
          ovf = (rem >= (NUM_W'(oa) << CH_W));
        end else begin
          rem = rem_r[s-1][c];
          q   = q_r[s-1][c];
          ovf = ovf_r[s-1][c];
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
          sh = NUM_W'(oa) << (CH_W - 1 - s * DIV_STEPS - j);
          if (rem >= sh) begin
            rem = rem - sh;
            q   = {q[CH_W-2:0], 1'b1};
          end else begin
            q   = {q[CH_W-2:0], 1'b0};
          end
        end
        if (s == LAST) begin
          if (oa == '0) begin
            q = '0;
          end else if (ovf) begin
            q = FULL_LEVEL;
          end
        end else begin
          rem_nxt[s][c] = rem;
          ovf_nxt[s][c] = ovf;
        end
        q_nxt[s][c] = q;
      end
    end
  end

  // Payload registers, loaded with their stage
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en[s]) begin
        q_r[s]  <= q_nxt[s];
        oa_r[s] <= oa_nxt[s];
        if (s < LAST) begin
          rem_r[s] <= rem_nxt[s];
          ovf_r[s] <= ovf_nxt[s];
        end
      end
    end
  end

endmodule

[src/rgba_source_over_blend.sv]
// ----------------------------------------------------------------------------
// rgba_source_over_blend: source-over compositing of 8-bit RGBA pixels
// Blends a straight-alpha source pixel over a destination pixel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one source/destination pixel pair per item; out_ch carries
//   the blended pixel. Both are valid/ready channels; an item moves on a
//   rising edge with valid and ready high.
//   Five stages form the products and the output alpha, then four stages of
//   a restoring divider (two quotient bits per stage) divide each color by
//   that alpha. Throughput is one pixel per cycle while out_ch.ready stays
//   high; every stage has its own valid bit and ready chain, so bubbles
//   close up.
//   When the receiver stalls, the result holds in the output register and
//   the stages behind it keep filling until the pipeline is full; only then
//   does in_ch.ready drop. Nothing is lost or repeated.
//   A synchronous reset (rst_n low) empties the pipeline; data in flight is
//   dropped. Colors saturate at 255; a zero output alpha gives an all-zero
//   pixel.
// ----------------------------------------------------------------------------
module rgba_source_over_blend import rsob_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  rsob_in_if.sink    in_ch,
  rsob_out_if.source out_ch
);

  pix_t in_pix;
  mix_t f_mix;
  logic f_valid;
  logic f_ready;
  res_t d_res;
  logic d_valid;

  // Pack the input channel
  always_comb begin
    in_pix.src_col[0] = in_ch.src_red;
    in_pix.src_col[1] = in_ch.src_green;
    in_pix.src_col[2] = in_ch.src_blue;
    in_pix.src_alpha  = in_ch.src_alpha;
    in_pix.dst_col[0] = in_ch.dst_red;
    in_pix.dst_col[1] = in_ch.dst_green;
    in_pix.dst_col[2] = in_ch.dst_blue;
    in_pix.dst_alpha  = in_ch.dst_alpha;
  end

  rsob_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_pix    (in_pix),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_mix   (f_mix)
  );

  rsob_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_mix    (f_mix),
    .out_valid (d_valid),
    .out_ready (out_ch.ready),
    .out_res   (d_res)
  );

  // Drive the result channel
  assign out_ch.valid           = d_valid;
  assign out_ch.out_red         = d_res.col[0];
  assign out_ch.out_green       = d_res.col[1];
  assign out_ch.out_blue        = d_res.col[2];
  assign out_ch.out_alpha_level = d_res.alpha;

`ifndef NO_ASSERTIONS
  // Zero alpha forces a fully transparent black pixel
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_alpha_level == 8'd0 |->
      out_ch.out_red == 8'd0 && out_ch.out_green == 8'd0 && out_ch.out_blue == 8'd0)
    else $error("nonzero color with zero output alpha");

  // A numerator item stalled at the divider holds until taken
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !f_ready |=> f_valid && $stable(f_mix))
    else $error("internal item changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !f_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
